// ===== rtl/sd_spi_init_and_block_read_macros.svh =====
// ----------------------------------------------------------------------------
// SD SPI sequencer assertion macros
// Concurrent assertion forms used by the sequencer core.
// ----------------------------------------------------------------------------
`ifndef SD_SPI_INIT_AND_BLOCK_READ_MACROS_SVH
`define SD_SPI_INIT_AND_BLOCK_READ_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SDSPI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDSPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// SD SPI sequencer package
// Types, codes and constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int SectorBytes = 512;
  localparam int SectorCntW  = $clog2(SectorBytes + 1);
  localparam int ByteCntW    = (SectorCntW > 8) ? SectorCntW : 8;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegWakeBytes    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegIdleTries    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegReadyTries   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTokenTries   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRespPolls    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSlowDivider  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegFastDivider  = 3'd6;

  localparam logic [7:0]  WakeBytesRst   = 8'd20;
  localparam logic [7:0]  IdleTriesRst   = 8'd20;
  localparam logic [15:0] ReadyTriesRst  = 16'd1500;
  localparam logic [15:0] TokenTriesRst  = 16'd1000;
  localparam logic [7:0]  RespPollsRst   = 8'd8;
  localparam logic [7:0]  SlowDividerRst = 8'd255;
  localparam logic [7:0]  FastDividerRst = 8'd0;

  // Action codes of an input item.
  localparam logic [2:0] ActInit   = 3'd0;
  localparam logic [2:0] ActRead   = 3'd1;
  localparam logic [2:0] ActDetect = 3'd2;
  localparam logic [2:0] ActDeinit = 3'd3;
  localparam logic [2:0] ActReply  = 3'd4;

  // Status codes.
  localparam logic [3:0] StOk          = 4'd0;
  localparam logic [3:0] StCmd0NoResp  = 4'd1;
  localparam logic [3:0] StCmd0Bad     = 4'd2;
  localparam logic [3:0] StCmd8Bad     = 4'd3;
  localparam logic [3:0] StEchoBad     = 4'd4;
  localparam logic [3:0] StCmd55Bad    = 4'd5;
  localparam logic [3:0] StAcmd41Bad   = 4'd6;
  localparam logic [3:0] StAcmd41Tmo   = 4'd7;
  localparam logic [3:0] StNoHighCap   = 4'd8;
  localparam logic [3:0] StReadReject  = 4'd9;
  localparam logic [3:0] StTokenTmo    = 4'd10;
  localparam logic [3:0] StNoCard      = 4'd11;

  typedef struct packed {
    logic [7:0]  wake_bytes;
    logic [7:0]  idle_tries;
    logic [15:0] ready_tries;
    logic [15:0] token_tries;
    logic [7:0]  response_polls;
    logic [7:0]  slow_divider;
    logic [7:0]  fast_divider;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] lba;
    logic [7:0]  reply_byte;
  } in_item_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       select_high;
    logic [7:0] clock_divider;
    logic       data_valid;
    logic [7:0] sector_byte;
    logic       data_last;
    logic       done_res;
    logic [3:0] status;
  } result_t;

  // A count register of zero behaves as one.
  function automatic logic [15:0] at_least_one(logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

// ===== rtl/sdspi_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// SD SPI configuration registers
// Holds the count and divider registers written through the plain write port.
// ----------------------------------------------------------------------------
module sdspi_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sdspi_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sdspi_pkg::CfgDataW-1:0] cfg_wdata_i,
  output sdspi_pkg::cfg_t                cfg_o
);
  import sdspi_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wake_bytes     <= WakeBytesRst;
      cfg_q.idle_tries     <= IdleTriesRst;
      cfg_q.ready_tries    <= ReadyTriesRst;
      cfg_q.token_tries    <= TokenTriesRst;
      cfg_q.response_polls <= RespPollsRst;
      cfg_q.slow_divider   <= SlowDividerRst;
      cfg_q.fast_divider   <= FastDividerRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegWakeBytes:   cfg_q.wake_bytes     <= cfg_wdata_i[7:0];
        RegIdleTries:   cfg_q.idle_tries     <= cfg_wdata_i[7:0];
        RegReadyTries:  cfg_q.ready_tries    <= cfg_wdata_i;
        RegTokenTries:  cfg_q.token_tries    <= cfg_wdata_i;
        RegRespPolls:   cfg_q.response_polls <= cfg_wdata_i[7:0];
        RegSlowDivider: cfg_q.slow_divider   <= cfg_wdata_i[7:0];
        RegFastDivider: cfg_q.fast_divider   <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/sdspi_in_stage.sv =====
// ----------------------------------------------------------------------------
// SD SPI input register
// Captures one input item and holds it until the sequencer takes it.
// ----------------------------------------------------------------------------
module sdspi_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sdspi_pkg::in_item_t item_i,
  input  logic                take_i,
  output logic                valid_o,
  output sdspi_pkg::in_item_t item_o
);
  import sdspi_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  assign in_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/sdspi_seq.sv =====
// ----------------------------------------------------------------------------
// SD SPI sequencer core
// Holds operation state, works out one item's result per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "sd_spi_init_and_block_read_macros.svh"

module sdspi_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sdspi_pkg::cfg_t     cfg_i,
  input  sdspi_pkg::in_item_t item_i,
  input  logic                fire_i,
  output logic                res_valid_o,
  output sdspi_pkg::result_t  res_o
);
  import sdspi_pkg::*;

  typedef enum logic [3:0] {
    PhIdle, PhWake, PhCmd0, PhCmd8, PhR7, PhCmd55, PhAcmd41, PhCmd58,
    PhOcr, PhCmd17, PhToken, PhData, PhCrc
  } phase_e;

  typedef enum logic [1:0] {
    OpInit, OpRead, OpDetect, OpDeinit
  } op_e;

  localparam logic [5:0]  CmdGoIdle     = 6'd0;
  localparam logic [5:0]  CmdIfCond     = 6'd8;
  localparam logic [5:0]  CmdReadSingle = 6'd17;
  localparam logic [5:0]  CmdSendOpCond = 6'd41;
  localparam logic [5:0]  CmdAppCmd     = 6'd55;
  localparam logic [5:0]  CmdReadOcr    = 6'd58;
  localparam logic [31:0] ArgIfCond     = 32'h0000_01AA;
  localparam logic [31:0] ArgHighCap    = 32'h4000_0000;
  localparam logic [11:0] EchoPattern   = 12'h1AA;
  localparam logic [7:0]  CrcGoIdle     = 8'h95;
  localparam logic [7:0]  CrcIfCond     = 8'h87;
  localparam logic [7:0]  FillByte      = 8'hFF;
  localparam logic [7:0]  StartToken    = 8'hFE;
  localparam logic [7:0]  CmdStartBits  = 8'h40;
  localparam logic [7:0]  R1Idle        = 8'h01;
  localparam logic [7:0]  R1Ready       = 8'h00;
  localparam logic [2:0]  FrameCrc      = 3'd5;
  localparam logic [2:0]  FramePoll     = 3'd6;

  phase_e                phase_q, phase_d;
  op_e                   op_q, op_d;
  logic [2:0]            frame_q, frame_d;
  logic [7:0]            poll_q, poll_d;
  logic [15:0]           retry_q, retry_d;
  logic [ByteCntW-1:0]   byte_cnt_q, byte_cnt_d;
  logic [5:0]            cmd_q, cmd_d;
  logic [31:0]           arg_q, arg_d;
  logic [31:0]           shift_q, shift_d;
  logic                  select_q, select_d;
  logic [7:0]            divider_q, divider_d;

  logic [ByteCntW-1:0]   cnt_inc;
  logic [15:0]           retry_inc;
  logic [7:0]            poll_inc;
  logic [2:0]            frame_inc;
  logic [31:0]           shift_next;
  logic [7:0]            reply;
  logic                  start_en;
  phase_e                start_phase;
  logic [5:0]            start_cmd;
  logic [31:0]           start_arg;
  result_t               res;

  function automatic logic [7:0] frame_byte(logic [2:0] idx, logic [5:0] cmd,
                                            logic [31:0] arg);
    unique case (idx)
      3'd0:    return CmdStartBits | {2'b00, cmd};
      3'd1:    return arg[31:24];
      3'd2:    return arg[23:16];
      3'd3:    return arg[15:8];
      3'd4:    return arg[7:0];
      default: begin
        if (cmd == CmdGoIdle) begin
          return CrcGoIdle;
        end else if (cmd == CmdIfCond) begin
          return CrcIfCond;
        end
        return FillByte;
      end
    endcase
  endfunction

  assign reply      = item_i.reply_byte;
  assign cnt_inc    = byte_cnt_q + ByteCntW'(1);
  assign retry_inc  = retry_q + 16'd1;
  assign poll_inc   = poll_q + 8'd1;
  assign frame_inc  = frame_q + 3'd1;
  assign shift_next = {shift_q[23:0], reply};

  always_comb begin
    phase_d     = phase_q;
    op_d        = op_q;
    frame_d     = frame_q;
    poll_d      = poll_q;
    retry_d     = retry_q;
    byte_cnt_d  = byte_cnt_q;
    cmd_d       = cmd_q;
    arg_d       = arg_q;
    shift_d     = shift_q;
    select_d    = select_q;
    divider_d   = divider_q;
    start_en    = 1'b0;
    start_phase = PhCmd0;
    start_cmd   = CmdGoIdle;
    start_arg   = 32'd0;
    res         = '0;
    res_valid_o = 1'b1;

    if (item_i.action > ActReply) begin
      res_valid_o = 1'b0;
    end else if (item_i.action == ActReply && phase_q == PhIdle) begin
      res_valid_o = 1'b0;
    end else begin
      unique case (item_i.action)
        ActInit, ActDetect: begin
          op_d           = (item_i.action == ActDetect) ? OpDetect : OpInit;
          divider_d      = cfg_i.slow_divider;
          select_d       = 1'b1;
          byte_cnt_d     = '0;
          retry_d        = 16'd0;
          phase_d        = PhWake;
          res.send_valid = 1'b1;
          res.send_byte  = FillByte;
        end
        ActRead: begin
          op_d        = OpRead;
          start_en    = 1'b1;
          start_phase = PhCmd17;
          start_cmd   = CmdReadSingle;
          start_arg   = item_i.lba;
        end
        ActDeinit: begin
          op_d         = OpDeinit;
          select_d     = 1'b1;
          divider_d    = cfg_i.slow_divider;
          phase_d      = PhIdle;
          res.done_res = 1'b1;
          res.status   = StOk;
        end
        default: begin
          unique case (phase_q)
            PhWake: begin
              byte_cnt_d = cnt_inc;
              if (16'(cnt_inc) < at_least_one({8'd0, cfg_i.wake_bytes})) begin
                res.send_valid = 1'b1;
                res.send_byte  = FillByte;
              end else begin
                select_d  = 1'b0;
                retry_d   = 16'd0;
                start_en  = 1'b1;
                start_phase = PhCmd0;
                start_cmd = CmdGoIdle;
                start_arg = 32'd0;
              end
            end
            PhR7, PhOcr: begin
              shift_d    = shift_next;
              byte_cnt_d = cnt_inc;
              if (cnt_inc < ByteCntW'(4)) begin
                res.send_valid = 1'b1;
                res.send_byte  = FillByte;
              end else if (phase_q == PhR7) begin
                if (shift_next[11:0] != EchoPattern) begin
                  select_d     = 1'b1;
                  divider_d    = cfg_i.slow_divider;
                  phase_d      = PhIdle;
                  res.done_res = 1'b1;
                  res.status   = StEchoBad;
                end else begin
                  retry_d     = 16'd0;
                  start_en    = 1'b1;
                  start_phase = PhCmd55;
                  start_cmd   = CmdAppCmd;
                  start_arg   = 32'd0;
                end
              end else if (!shift_next[30]) begin
                select_d     = 1'b1;
                divider_d    = cfg_i.slow_divider;
                phase_d      = PhIdle;
                res.done_res = 1'b1;
                res.status   = StNoHighCap;
              end else begin
                divider_d    = cfg_i.fast_divider;
                phase_d      = PhIdle;
                res.done_res = 1'b1;
                res.status   = StOk;
              end
            end
            PhToken: begin
              retry_d = retry_inc;
              if (reply == StartToken) begin
                phase_d        = PhData;
                byte_cnt_d     = '0;
                res.send_valid = 1'b1;
                res.send_byte  = FillByte;
              end else if (retry_inc >= at_least_one(cfg_i.token_tries)) begin
                phase_d      = PhIdle;
                res.done_res = 1'b1;
                res.status   = StTokenTmo;
              end else begin
                res.send_valid = 1'b1;
                res.send_byte  = FillByte;
              end
            end
            PhData: begin
              res.data_valid  = 1'b1;
              res.sector_byte = reply;
              res.send_valid  = 1'b1;
              res.send_byte   = FillByte;
              if (cnt_inc >= ByteCntW'(SectorBytes)) begin
                res.data_last = 1'b1;
                phase_d       = PhCrc;
                byte_cnt_d    = '0;
              end else begin
                byte_cnt_d = cnt_inc;
              end
            end
            PhCrc: begin
              byte_cnt_d = cnt_inc;
              if (cnt_inc < ByteCntW'(2)) begin
                res.send_valid = 1'b1;
                res.send_byte  = FillByte;
              end else begin
                phase_d      = PhIdle;
                res.done_res = 1'b1;
                res.status   = StOk;
              end
            end
            default: begin
              if (frame_q < FrameCrc) begin
                frame_d        = frame_inc;
                res.send_valid = 1'b1;
                res.send_byte  = frame_byte(frame_inc, cmd_q, arg_q);
              end else if (frame_q == FrameCrc) begin
                frame_d        = FramePoll;
                poll_d         = 8'd0;
                res.send_valid = 1'b1;
                res.send_byte  = FillByte;
              end else begin
                poll_d = poll_inc;
                if (!reply[7] ||
                    {8'd0, poll_inc} >= at_least_one({8'd0, cfg_i.response_polls})) begin
                  unique case (phase_q)
                    PhCmd0: begin
                      retry_d = retry_inc;
                      if (reply == R1Idle) begin
                        if (op_q == OpDetect) begin
                          select_d     = 1'b1;
                          divider_d    = cfg_i.slow_divider;
                          phase_d      = PhIdle;
                          res.done_res = 1'b1;
                          res.status   = StOk;
                        end else begin
                          start_en    = 1'b1;
                          start_phase = PhCmd8;
                          start_cmd   = CmdIfCond;
                          start_arg   = ArgIfCond;
                        end
                      end else if (retry_inc < at_least_one({8'd0, cfg_i.idle_tries})) begin
                        start_en    = 1'b1;
                        start_phase = PhCmd0;
                        start_cmd   = CmdGoIdle;
                        start_arg   = 32'd0;
                      end else begin
                        select_d     = 1'b1;
                        divider_d    = cfg_i.slow_divider;
                        phase_d      = PhIdle;
                        res.done_res = 1'b1;
                        if (op_q == OpDetect) begin
                          res.status = StNoCard;
                        end else if (reply == FillByte) begin
                          res.status = StCmd0NoResp;
                        end else begin
                          res.status = StCmd0Bad;
                        end
                      end
                    end
                    PhCmd8: begin
                      if (reply != R1Idle) begin
                        select_d     = 1'b1;
                        divider_d    = cfg_i.slow_divider;
                        phase_d      = PhIdle;
                        res.done_res = 1'b1;
                        res.status   = StCmd8Bad;
                      end else begin
                        phase_d        = PhR7;
                        byte_cnt_d     = '0;
                        shift_d        = 32'd0;
                        res.send_valid = 1'b1;
                        res.send_byte  = FillByte;
                      end
                    end
                    PhCmd55: begin
                      if (reply != R1Idle) begin
                        select_d     = 1'b1;
                        divider_d    = cfg_i.slow_divider;
                        phase_d      = PhIdle;
                        res.done_res = 1'b1;
                        res.status   = StCmd55Bad;
                      end else begin
                        start_en    = 1'b1;
                        start_phase = PhAcmd41;
                        start_cmd   = CmdSendOpCond;
                        start_arg   = ArgHighCap;
                      end
                    end
                    PhAcmd41: begin
                      retry_d = retry_inc;
                      if (reply == R1Ready) begin
                        start_en    = 1'b1;
                        start_phase = PhCmd58;
                        start_cmd   = CmdReadOcr;
                        start_arg   = 32'd0;
                      end else if (reply != R1Idle) begin
                        select_d     = 1'b1;
                        divider_d    = cfg_i.slow_divider;
                        phase_d      = PhIdle;
                        res.done_res = 1'b1;
                        res.status   = StAcmd41Bad;
                      end else if (retry_inc < at_least_one(cfg_i.ready_tries)) begin
                        start_en    = 1'b1;
                        start_phase = PhCmd55;
                        start_cmd   = CmdAppCmd;
                        start_arg   = 32'd0;
                      end else begin
                        select_d     = 1'b1;
                        divider_d    = cfg_i.slow_divider;
                        phase_d      = PhIdle;
                        res.done_res = 1'b1;
                        res.status   = StAcmd41Tmo;
                      end
                    end
                    PhCmd58: begin
                      phase_d        = PhOcr;
                      byte_cnt_d     = '0;
                      shift_d        = 32'd0;
                      res.send_valid = 1'b1;
                      res.send_byte  = FillByte;
                    end
                    default: begin
                      if (reply != R1Ready) begin
                        phase_d      = PhIdle;
                        res.done_res = 1'b1;
                        res.status   = StReadReject;
                      end else begin
                        phase_d        = PhToken;
                        retry_d        = 16'd0;
                        res.send_valid = 1'b1;
                        res.send_byte  = FillByte;
                      end
                    end
                  endcase
                end else begin
                  res.send_valid = 1'b1;
                  res.send_byte  = FillByte;
                end
              end
            end
          endcase
        end
      endcase
    end

    if (start_en) begin
      phase_d        = start_phase;
      cmd_d          = start_cmd;
      arg_d          = start_arg;
      frame_d        = 3'd0;
      poll_d         = 8'd0;
      res.send_valid = 1'b1;
      res.send_byte  = CmdStartBits | {2'b00, start_cmd};
    end

    res.select_high   = select_d;
    res.clock_divider = divider_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      op_q       <= OpInit;
      frame_q    <= 3'd0;
      poll_q     <= 8'd0;
      retry_q    <= 16'd0;
      byte_cnt_q <= '0;
      cmd_q      <= CmdGoIdle;
      arg_q      <= 32'd0;
      shift_q    <= 32'd0;
      select_q   <= 1'b1;
      divider_q  <= SlowDividerRst;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      op_q       <= op_d;
      frame_q    <= frame_d;
      poll_q     <= poll_d;
      retry_q    <= retry_d;
      byte_cnt_q <= byte_cnt_d;
      cmd_q      <= cmd_d;
      arg_q      <= arg_d;
      shift_q    <= shift_d;
      select_q   <= select_d;
      divider_q  <= divider_d;
    end
  end

  assign res_o = res;

  `SDSPI_ASSERT_IMPL(a_done_no_send, res_valid_o, !(res.done_res && res.send_valid), "done with request")
  `SDSPI_ASSERT_IMPL(a_last_is_data, res_valid_o && res.data_last, res.data_valid, "last without data")
  `SDSPI_ASSERT_IMPL(a_status_done, res_valid_o && (res.status != StOk), res.done_res, "status without done")
  `SDSPI_ASSERT_NEXT(a_last_to_crc, fire_i && res_valid_o && res.data_last, phase_q == PhCrc, "no crc phase")

endmodule

// ===== rtl/sdspi_out_stage.sv =====
// ----------------------------------------------------------------------------
// SD SPI result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module sdspi_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  sdspi_pkg::result_t res_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sdspi_pkg::result_t res_o
);
  import sdspi_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/sd_spi_init_and_block_read.sv =====
// ----------------------------------------------------------------------------
// SD card SPI-mode host sequencer
// Init, detect, single-block read and deinit over a byte exchange channel.
// ----------------------------------------------------------------------------
// The input channel carries commands (init, read, detect, deinit) and, with
// action 4, the byte received in the previous exchange. Each accepted item
// except an ignored one yields one result item on the output channel: a
// byte to exchange, chip select level, clock divider, a sector data byte
// and, at the end of an operation, done with its status.
// An item passes the input register and then the result register before
// its result is shown on the output channel. One item can be accepted
// every cycle while the result register is free; in use the pace is one
// item per SPI byte exchange. A stalled receiver holds the result
// register, and one further item waits in the input register before the
// input stalls.
// After reset the block is idle with chip select high and the slow divider,
// and the configuration registers hold their default counts. A command
// that arrives during an operation aborts it and starts the new one.
// ----------------------------------------------------------------------------
module sd_spi_init_and_block_read (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sdspi_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sdspi_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [2:0]                     action_i,
  input  logic [31:0]                    lba_i,
  input  logic [7:0]                     reply_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           send_valid_o,
  output logic [7:0]                     send_byte_o,
  output logic                           select_high_o,
  output logic [7:0]                     clock_divider_o,
  output logic                           data_valid_o,
  output logic [7:0]                     sector_byte_o,
  output logic                           data_last_o,
  output logic                           done_res_o,
  output logic [3:0]                     status_o
);
  import sdspi_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;
  in_item_t work_item;
  logic     work_valid;
  logic     out_free;
  logic     fire;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  assign in_item.action     = action_i;
  assign in_item.lba        = lba_i;
  assign in_item.reply_byte = reply_byte_i;

  assign fire = work_valid && out_free;

  sdspi_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sdspi_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (out_free),
    .valid_o    (work_valid),
    .item_o     (work_item)
  );

  sdspi_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_i      (work_item),
    .fire_i      (fire),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sdspi_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign send_valid_o    = out_res.send_valid;
  assign send_byte_o     = out_res.send_byte;
  assign select_high_o   = out_res.select_high;
  assign clock_divider_o = out_res.clock_divider;
  assign data_valid_o    = out_res.data_valid;
  assign sector_byte_o   = out_res.sector_byte;
  assign data_last_o     = out_res.data_last;
  assign done_res_o      = out_res.done_res;
  assign status_o        = out_res.status;

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// SD SPI host sequencer testbench
// Plays the card side of the byte exchanges for init, detect, read and
// deinit under several register settings. A scoreboard predicts every
// result item and checks it against the block.
// ----------------------------------------------------------------------------
module tb;
  import sdspi_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;

  localparam logic [2:0] ActUnusedLo = ActReply + 3'd1;
  localparam logic [2:0] ActUnusedHi = '1;

  localparam logic [5:0]  CmdGoIdle     = 6'd0;
  localparam logic [5:0]  CmdIfCond     = 6'd8;
  localparam logic [5:0]  CmdReadBlock  = 6'd17;
  localparam logic [5:0]  CmdSendOpCond = 6'd41;
  localparam logic [5:0]  CmdAppCmd     = 6'd55;
  localparam logic [5:0]  CmdReadOcr    = 6'd58;
  localparam logic [31:0] ArgIfCond     = 32'h0000_01AA;
  localparam logic [31:0] ArgHighCap    = 32'h4000_0000;
  localparam logic [7:0]  CmdStart      = 8'h40;
  localparam logic [7:0]  CrcGoIdle     = 8'h95;
  localparam logic [7:0]  CrcIfCond     = 8'h87;
  localparam logic [7:0]  FillByte      = 8'hFF;
  localparam logic [7:0]  TokenStart    = 8'hFE;
  localparam logic [7:0]  R1Idle        = 8'h01;
  localparam logic [7:0]  R1Ready       = 8'h00;
  localparam logic [7:0]  EchoPattern   = 8'hAA;
  localparam logic [11:0] EchoCheck     = 12'h1AA;
  localparam logic [2:0]  FrameCrc      = 3'd5;
  localparam logic [2:0]  FramePoll     = 3'd6;

  typedef enum logic [4:0] {
    PhIdle, PhWake, PhCmd0, PhCmd8, PhR7, PhCmd55, PhAcmd41, PhCmd58,
    PhOcr, PhCmd17, PhToken, PhData, PhCrc
  } seq_phase_e;

  class sd_host_board;
    logic [7:0]  wake_bytes, idle_tries, polls, slow_div, fast_div;
    logic [15:0] ready_tries, token_tries;

    seq_phase_e  phase;
    logic [2:0]  op;
    logic [2:0]  frame_idx;
    logic [7:0]  poll_cnt;
    logic [15:0] retry_cnt;
    logic [9:0]  byte_cnt;
    logic [5:0]  cmd_idx;
    logic [31:0] cmd_arg;
    logic [31:0] shift;
    logic [7:0]  last_resp;
    logic        sel;
    logic [7:0]  div;

    result_t     cur;
    result_t     host_results_q[$];
    int unsigned errors;
    int unsigned sectors_read;

    function new();
      wake_bytes = WakeBytesRst;
      idle_tries = IdleTriesRst;
      ready_tries = ReadyTriesRst;
      token_tries = TokenTriesRst;
      polls = RespPollsRst;
      slow_div = SlowDividerRst;
      fast_div = FastDividerRst;
      phase = PhIdle;
      op = ActInit;
      frame_idx = '0;
      poll_cnt = '0;
      retry_cnt = '0;
      byte_cnt = '0;
      cmd_idx = '0;
      cmd_arg = '0;
      shift = '0;
      last_resp = FillByte;
      sel = 1'b1;
      div = slow_div;
      errors = 0;
      sectors_read = 0;
    endfunction

    function logic [15:0] min_one(logic [15:0] v);
      return (v == '0) ? 16'd1 : v;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        RegWakeBytes:   wake_bytes = val[7:0];
        RegIdleTries:   idle_tries = val[7:0];
        RegReadyTries:  ready_tries = val;
        RegTokenTries:  token_tries = val;
        RegRespPolls:   polls = val[7:0];
        RegSlowDivider: slow_div = val[7:0];
        RegFastDivider: fast_div = val[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return host_results_q.size();
    endfunction

    function void ask(logic [7:0] b);
      cur.send_valid = 1'b1;
      cur.send_byte = b;
    endfunction

    function void end_op(logic [3:0] st);
      phase = PhIdle;
      cur.done_res = 1'b1;
      cur.status = st;
    endfunction

    function void fail_init(logic [3:0] st);
      sel = 1'b1;
      div = slow_div;
      end_op(st);
    endfunction

    function logic [7:0] frame_byte();
      case (frame_idx)
        3'd0: return CmdStart | {2'b00, cmd_idx};
        3'd1: return cmd_arg[31:24];
        3'd2: return cmd_arg[23:16];
        3'd3: return cmd_arg[15:8];
        3'd4: return cmd_arg[7:0];
        default: begin
          if (cmd_idx == CmdGoIdle) return CrcGoIdle;
          if (cmd_idx == CmdIfCond) return CrcIfCond;
          return FillByte;
        end
      endcase
    endfunction

    function void begin_cmd(seq_phase_e ph, logic [5:0] idx, logic [31:0] arg);
      phase = ph;
      cmd_idx = idx;
      cmd_arg = arg;
      frame_idx = '0;
      poll_cnt = '0;
      ask(frame_byte());
    endfunction

    function void take_r1(logic [7:0] r);
      case (phase)
        PhCmd0: begin
          retry_cnt++;
          if (r == R1Idle) begin
            if (op == ActDetect) begin
              sel = 1'b1;
              div = slow_div;
              end_op(StOk);
            end else begin
              begin_cmd(PhCmd8, CmdIfCond, ArgIfCond);
            end
          end else if (retry_cnt < min_one(idle_tries)) begin
            begin_cmd(PhCmd0, CmdGoIdle, '0);
          end else if (op == ActDetect) begin
            sel = 1'b1;
            div = slow_div;
            end_op(StNoCard);
          end else begin
            fail_init((r == FillByte) ? StCmd0NoResp : StCmd0Bad);
          end
        end
        PhCmd8: begin
          if (r != R1Idle) begin
            fail_init(StCmd8Bad);
          end else begin
            phase = PhR7;
            byte_cnt = '0;
            shift = '0;
            ask(FillByte);
          end
        end
        PhCmd55: begin
          if (r != R1Idle) fail_init(StCmd55Bad);
          else begin_cmd(PhAcmd41, CmdSendOpCond, ArgHighCap);
        end
        PhAcmd41: begin
          retry_cnt++;
          if (r == R1Ready) begin_cmd(PhCmd58, CmdReadOcr, '0);
          else if (r != R1Idle) fail_init(StAcmd41Bad);
          else if (retry_cnt < min_one(ready_tries)) begin_cmd(PhCmd55, CmdAppCmd, '0);
          else fail_init(StAcmd41Tmo);
        end
        PhCmd58: begin
          phase = PhOcr;
          byte_cnt = '0;
          shift = '0;
          ask(FillByte);
        end
        default: begin
          if (r != R1Ready) begin
            end_op(StReadReject);
          end else begin
            phase = PhToken;
            retry_cnt = '0;
            ask(FillByte);
          end
        end
      endcase
    endfunction

    function void advance_cmd(logic [7:0] b);
      if (frame_idx < FrameCrc) begin
        frame_idx++;
        ask(frame_byte());
      end else if (frame_idx == FrameCrc) begin
        frame_idx = FramePoll;
        poll_cnt = '0;
        ask(FillByte);
      end else begin
        poll_cnt++;
        if (!b[7] || poll_cnt >= min_one(polls)) begin
          last_resp = b;
          take_r1(b);
        end else begin
          ask(FillByte);
        end
      end
    endfunction

    function void take_byte(logic [7:0] b);
      case (phase)
        PhWake: begin
          byte_cnt++;
          if (byte_cnt < min_one(wake_bytes)) begin
            ask(FillByte);
          end else begin
            sel = 1'b0;
            retry_cnt = '0;
            begin_cmd(PhCmd0, CmdGoIdle, '0);
          end
        end
        PhR7, PhOcr: begin
          shift = {shift[23:0], b};
          byte_cnt++;
          if (byte_cnt < 4) begin
            ask(FillByte);
          end else if (phase == PhR7) begin
            if (shift[11:0] != EchoCheck) begin
              fail_init(StEchoBad);
            end else begin
              retry_cnt = '0;
              begin_cmd(PhCmd55, CmdAppCmd, '0);
            end
          end else if ((shift & ArgHighCap) == '0) begin
            fail_init(StNoHighCap);
          end else begin
            div = fast_div;
            end_op(StOk);
          end
        end
        PhToken: begin
          retry_cnt++;
          if (b == TokenStart) begin
            phase = PhData;
            byte_cnt = '0;
            ask(FillByte);
          end else if (retry_cnt >= min_one(token_tries)) begin
            end_op(StTokenTmo);
          end else begin
            ask(FillByte);
          end
        end
        PhData: begin
          cur.data_valid = 1'b1;
          cur.sector_byte = b;
          byte_cnt++;
          if (byte_cnt >= SectorBytes) begin
            cur.data_last = 1'b1;
            phase = PhCrc;
            byte_cnt = '0;
            sectors_read++;
          end
          ask(FillByte);
        end
        PhCrc: begin
          byte_cnt++;
          if (byte_cnt < 2) ask(FillByte);
          else end_op(StOk);
        end
        default: advance_cmd(b);
      endcase
    endfunction

    // Returns whether the item yields a result.
    function bit note_input(logic [2:0] act, logic [31:0] lba, logic [7:0] b);
      if (act > ActReply) return 1'b0;
      if (act == ActReply && phase == PhIdle) return 1'b0;
      cur = '0;
      case (act)
        ActInit, ActDetect: begin
          op = act;
          div = slow_div;
          sel = 1'b1;
          byte_cnt = '0;
          retry_cnt = '0;
          phase = PhWake;
          ask(FillByte);
        end
        ActRead: begin
          op = act;
          begin_cmd(PhCmd17, CmdReadBlock, lba);
        end
        ActDeinit: begin
          op = act;
          sel = 1'b1;
          div = slow_div;
          end_op(StOk);
        end
        default: take_byte(b);
      endcase
      cur.select_high = sel;
      cur.clock_divider = div;
      host_results_q.push_back(cur);
      return 1'b1;
    endfunction

    function void cmp(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_output(result_t got);
      result_t want;
      if (host_results_q.size() == 0) begin
        $display("%0t: result %h arrived with none expected", $time, got);
        errors++;
        return;
      end
      want = host_results_q.pop_front();
      cmp("send_valid", want.send_valid, got.send_valid);
      cmp("send_byte", want.send_byte, got.send_byte);
      cmp("select_high", want.select_high, got.select_high);
      cmp("clock_divider", want.clock_divider, got.clock_divider);
      cmp("data_valid", want.data_valid, got.data_valid);
      cmp("sector_byte", want.sector_byte, got.sector_byte);
      cmp("data_last", want.data_last, got.data_last);
      cmp("done_res", want.done_res, got.done_res);
      cmp("status", want.status, got.status);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [2:0]          action_i = ActDeinit;
  logic [31:0]         lba_i = '0;
  logic [7:0]          reply_byte_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                send_valid_o;
  logic [7:0]          send_byte_o;
  logic                select_high_o;
  logic [7:0]          clock_divider_o;
  logic                data_valid_o;
  logic [7:0]          sector_byte_o;
  logic                data_last_o;
  logic                done_res_o;
  logic [3:0]          status_o;

  sd_host_board        sb;
  bit                  calm;
  bit                  card_absent;
  bit                  token_never;
  int unsigned         counted;
  int unsigned         stall_left;
  logic [CfgDataW-1:0] reg_plan [int'(RegFastDivider) + 1];

  sd_spi_init_and_block_read dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk_i) begin
    int unsigned g;
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      g = pick_gap();
      out_ready_i <= (g == 0);
      if (g > 0) stall_left = g - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_output({send_valid_o, send_byte_o, select_high_o, clock_divider_o,
                       data_valid_o, sector_byte_o, data_last_o, done_res_o, status_o});
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("FAIL sd_spi_init_and_block_read");
    $finish;
  end

  // The card side: answers each exchange from the predicted sequencer state.
  function automatic logic [7:0] card_byte();
    logic [7:0] b;
    b = 8'($urandom);
    case (sb.phase)
      PhCmd0, PhCmd8, PhCmd55, PhAcmd41, PhCmd58, PhCmd17: begin
        if (sb.frame_idx == FramePoll) begin
          if (sb.phase == PhCmd0 && card_absent) begin
            b = FillByte;
          end else if (sb.poll_cnt + 1 < sb.min_one(sb.polls) && $urandom_range(0, 2) == 0) begin
            b[7] = 1'b1;
          end else if ($urandom_range(0, 29) != 0) begin
            b[7] = 1'b0;
            case (sb.phase)
              PhCmd0:   if ($urandom_range(0, 4) != 0) b = R1Idle;
              PhCmd8, PhCmd55: if ($urandom_range(0, 19) != 0) b = R1Idle;
              PhAcmd41: begin
                if ($urandom_range(0, 24) != 0) begin
                  b = ($urandom_range(0, 2) == 0) ? R1Idle : R1Ready;
                end
              end
              PhCmd58: ;
              default:  if ($urandom_range(0, 14) != 0) b = R1Ready;
            endcase
          end
        end
      end
      PhR7: begin
        if ($urandom_range(0, 19) != 0) begin
          if (sb.byte_cnt == 2) b[3:0] = EchoCheck[11:8];
          else if (sb.byte_cnt == 3) b = EchoPattern;
        end
      end
      PhOcr: if (sb.byte_cnt == 0 && $urandom_range(0, 9) != 0) b[6] = 1'b1;
      PhToken: begin
        if (!token_never && (sb.retry_cnt + 1 >= sb.min_one(sb.token_tries) ||
                             $urandom_range(0, 2) != 0)) begin
          b = TokenStart;
        end else if (b == TokenStart) begin
          b = FillByte;
        end
      end
      default: ;
    endcase
    return b;
  endfunction

  task automatic push_item(input logic [2:0] act, input logic [31:0] lba,
                           input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    lba_i <= lba;
    reply_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (sb.note_input(act, lba, b)) counted++;
    @(negedge clk_i);
  endtask

  // A nonzero budget ends the operation with a deinit after that many items.
  task automatic run_op(input logic [2:0] act, input bit may_abort,
                        input int unsigned budget);
    int unsigned sent;
    sent = 0;
    calm = ($urandom_range(0, 5) == 0);
    card_absent = (act == ActInit || act == ActDetect) && $urandom_range(0, 7) == 0 &&
                  sb.min_one(sb.idle_tries) * sb.min_one(sb.polls) <= 400;
    token_never = may_abort && $urandom_range(0, 5) == 0 && sb.min_one(sb.token_tries) <= 40;
    push_item(act, 32'($urandom), 8'($urandom));
    while (sb.phase != PhIdle) begin
      if (budget != 0 && sent >= budget) begin
        push_item(ActDeinit, 32'($urandom), 8'($urandom));
        budget = 0;
      end else if (may_abort && $urandom_range(0, 299) == 0) begin
        push_item(3'($urandom_range(ActInit, ActDeinit)), 32'($urandom), 8'($urandom));
      end else if ($urandom_range(0, 79) == 0) begin
        push_item(3'($urandom_range(ActUnusedLo, ActUnusedHi)), 32'($urandom), 8'($urandom));
      end else begin
        push_item(ActReply, 32'($urandom), card_byte());
      end
      sent++;
    end
    if ($urandom_range(0, 3) == 0) push_item(ActReply, 32'($urandom), 8'($urandom));
  endtask

  task automatic run_phase(input int unsigned target);
    int unsigned start;
    int unsigned r;
    start = counted;
    while (counted - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 40) run_op(ActInit, 1'b1, 0);
      else if (r < 70) run_op(ActRead, 1'b1, $urandom_range(6, 24));
      else if (r < 88) run_op(ActDetect, 1'b1, 0);
      else run_op(ActDeinit, 1'b1, 0);
    end
  endtask

  // Registers change only with the sequencer idle and every result drained.
  task automatic settle();
    if (sb.phase != PhIdle) push_item(ActDeinit, 32'($urandom), 8'($urandom));
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic apply_plan();
    for (int i = RegWakeBytes; i <= RegFastDivider; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CfgIdxW'(i);
      cfg_wdata_i <= reg_plan[i];
      sb.set_reg(CfgIdxW'(i), reg_plan[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    counted = 0;
    stall_left = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_item(ActReply, '1, 8'hFF);
    push_item(ActUnusedLo, 32'h0, 8'h00);
    push_item(ActUnusedLo + 3'd1, '1, 8'hFF);
    push_item(ActUnusedHi, 32'h0, 8'h00);
    push_item(ActDeinit, '1, 8'hFF);
    push_item(ActRead, 32'hFFFF_FFFF, 8'h00);
    repeat (6) push_item(ActReply, 32'h0, 8'hFF);
    push_item(ActReply, 32'h0, 8'h05);
    push_item(ActRead, 32'h0, 8'hFF);
    repeat (3) push_item(ActReply, '1, 8'h00);
    push_item(ActInit, 32'h0, 8'h00);
    repeat (2) push_item(ActReply, '1, 8'hFF);
    push_item(ActDetect, '1, 8'hFF);
    push_item(ActDeinit, 32'h0, 8'h00);

    run_phase(25);

    settle();
    reg_plan[RegWakeBytes] = 16'd1;
    reg_plan[RegIdleTries] = 16'd1;
    reg_plan[RegReadyTries] = 16'd1;
    reg_plan[RegTokenTries] = 16'd1;
    reg_plan[RegRespPolls] = 16'd1;
    reg_plan[RegSlowDivider] = 16'd0;
    reg_plan[RegFastDivider] = 16'd255;
    apply_plan();
    run_phase(10);

    settle();
    reg_plan[RegWakeBytes] = 16'd0;
    reg_plan[RegIdleTries] = 16'd0;
    reg_plan[RegReadyTries] = 16'd0;
    reg_plan[RegTokenTries] = 16'd0;
    reg_plan[RegRespPolls] = 16'd0;
    reg_plan[RegSlowDivider] = 16'd255;
    reg_plan[RegFastDivider] = 16'd0;
    apply_plan();
    run_phase(10);

    settle();
    reg_plan[RegWakeBytes] = {8'($urandom), 8'd40};
    reg_plan[RegIdleTries] = {8'($urandom), 8'd255};
    reg_plan[RegReadyTries] = 16'hFFFF;
    reg_plan[RegTokenTries] = 16'hFFFF;
    reg_plan[RegRespPolls] = {8'($urandom), 8'd255};
    reg_plan[RegSlowDivider] = 16'($urandom);
    reg_plan[RegFastDivider] = 16'($urandom);
    apply_plan();
    run_phase(10);

    settle();
    reg_plan[RegWakeBytes] = {8'($urandom), 8'($urandom_range(1, 30))};
    reg_plan[RegIdleTries] = {8'($urandom), 8'($urandom_range(1, 8))};
    reg_plan[RegReadyTries] = 16'($urandom_range(1, 10));
    reg_plan[RegTokenTries] = 16'($urandom_range(1, 40));
    reg_plan[RegRespPolls] = {8'($urandom), 8'($urandom_range(1, 12))};
    reg_plan[RegSlowDivider] = 16'($urandom);
    reg_plan[RegFastDivider] = 16'($urandom);
    apply_plan();
    run_phase(10);

    while (sb.sectors_read < 1) run_op(ActRead, 1'b0, 0);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS sd_spi_init_and_block_read");
    end else begin
      $display("FAIL sd_spi_init_and_block_read");
    end
    $finish;
  end

endmodule

// ===== sd_spi_init_and_block_read.f =====
+incdir+rtl
rtl/sdspi_pkg.sv
rtl/sdspi_cfg_regs.sv
rtl/sdspi_in_stage.sv
rtl/sdspi_seq.sv
rtl/sdspi_out_stage.sv
rtl/sd_spi_init_and_block_read.sv
test/tb.sv
